FILE: rtl/core/i2cseq_pkg.sv
`default_nettype none
package i2cseq_pkg;

	// Size of the read buffer that received bytes are indexed into.
	localparam int READ_DEPTH = 8;

	// Action codes handed to the bus controller.
	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_START  = 3'd1;
	localparam logic [2:0] ACT_TX     = 3'd2;
	localparam logic [2:0] ACT_STOP   = 3'd3;
	localparam logic [2:0] ACT_RSTART = 3'd4;
	localparam logic [2:0] ACT_RCEN   = 3'd5;
	localparam logic [2:0] ACT_ACK    = 3'd6;

	// Sequencer phases.
	localparam logic [3:0] PH_ADDR    = 4'd0;
	localparam logic [3:0] PH_REG     = 4'd1;
	localparam logic [3:0] PH_DATA    = 4'd2;
	localparam logic [3:0] PH_TAIL    = 4'd3;
	localparam logic [3:0] PH_READDR  = 4'd4;
	localparam logic [3:0] PH_RCEN    = 4'd5;
	localparam logic [3:0] PH_RECV    = 4'd6;
	localparam logic [3:0] PH_RSTOP   = 4'd7;
	localparam logic [3:0] PH_DONE    = 4'd8;

	localparam logic CMD_START = 1'b0;

	typedef struct packed {
		logic       command;
		logic       read_mode;
		logic [7:0] addr_byte;
		logic [7:0] reg_addr;
		logic [7:0] write_byte;
		logic [2:0] last_index;
		logic       start_seen;
		logic       rx_full;
		logic [7:0] rx_data;
	} item_t;

	typedef struct packed {
		logic [3:0] phase;
		logic       mode;
		logic [7:0] addr;
		logic [7:0] regnum;
		logic [7:0] data;
		logic [2:0] last;
		logic [2:0] byte_count;
	} seq_state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx_byte;
		logic       nack;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [2:0] rx_index;
		logic       done_res;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/core/i2cseq_step.sv
`default_nettype none
module i2cseq_step
	import i2cseq_pkg::*;
(
	input  wire seq_state_t st,
	input  wire item_t      item,
	output seq_state_t      nxt,
	output result_t         res
);

	logic last_byte;

	// A byte is the final one at the requested index or when the buffer is full.
	assign last_byte = (st.byte_count == st.last) ||
		((int'(st.byte_count) + 1) >= READ_DEPTH);

	always_comb begin
		nxt = st;
		res = '0;
		if (item.command == CMD_START) begin
			nxt.mode       = item.read_mode;
			nxt.addr       = item.addr_byte;
			nxt.regnum     = item.reg_addr;
			nxt.data       = item.write_byte;
			nxt.last       = item.last_index;
			nxt.phase      = PH_ADDR;
			nxt.byte_count = '0;
			res.action     = ACT_START;
		end else if (!st.mode) begin
			unique case (st.phase)
				PH_ADDR: begin
					if (item.start_seen) begin
						res.action  = ACT_TX;
						res.tx_byte = st.addr;
						nxt.phase   = PH_REG;
					end
				end
				PH_REG: begin
					res.action  = ACT_TX;
					res.tx_byte = st.regnum;
					nxt.phase   = PH_DATA;
				end
				PH_DATA: begin
					res.action  = ACT_TX;
					res.tx_byte = st.data;
					nxt.phase   = PH_TAIL;
				end
				PH_TAIL: begin
					res.action   = ACT_STOP;
					res.done_res = 1'b1;
					nxt.phase    = PH_READDR;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (st.phase)
				PH_ADDR: begin
					if (item.start_seen) begin
						res.action  = ACT_TX;
						res.tx_byte = st.addr - 8'd1;
						nxt.phase   = PH_REG;
					end
				end
				PH_REG: begin
					res.action  = ACT_TX;
					res.tx_byte = st.regnum;
					nxt.phase   = PH_TAIL;
				end
				PH_TAIL: begin
					res.action = ACT_RSTART;
					nxt.phase  = PH_READDR;
				end
				PH_READDR: begin
					if (item.start_seen) begin
						res.action  = ACT_TX;
						res.tx_byte = st.addr;
						nxt.phase   = PH_RCEN;
					end
				end
				PH_RCEN: begin
					res.action = ACT_RCEN;
					nxt.phase  = PH_RECV;
				end
				PH_RECV: begin
					if (item.rx_full) begin
						res.action   = ACT_ACK;
						res.rx_valid = 1'b1;
						res.rx_byte  = item.rx_data;
						res.rx_index = st.byte_count;
						if (last_byte) begin
							res.nack  = 1'b1;
							nxt.phase = PH_RSTOP;
						end else begin
							nxt.byte_count = st.byte_count + 3'd1;
						end
					end else begin
						res.action = ACT_RCEN;
					end
				end
				PH_RSTOP: begin
					res.action   = ACT_STOP;
					res.done_res = 1'b1;
					nxt.phase    = PH_DONE;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/i2c_master_register_sequencer_core.sv
`default_nettype none
// Channel | Handshake          | Beat contents
// input   | in_valid/in_stall  | command, read_mode, addr_byte, reg_addr, write_byte,
//         |                    | last_index, start_seen, rx_full, rx_data
// output  | out_valid/out_stall| action, tx_byte, nack, rx_valid, rx_byte, rx_index, done_res
//
// Every input beat yields exactly one output beat, registered first in the input register
// and then in the result register.
// A new beat is accepted every cycle while the output side is not stalled.
// The sequencer state is updated in the same cycle the result register loads.
// Reset clears the sequencer state and both valid flags.
module i2c_master_register_sequencer_core
	import i2cseq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        command,
	input  wire        read_mode,
	input  wire  [7:0] addr_byte,
	input  wire  [7:0] reg_addr,
	input  wire  [7:0] write_byte,
	input  wire  [2:0] last_index,
	input  wire        start_seen,
	input  wire        rx_full,
	input  wire  [7:0] rx_data,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [2:0] action,
	output logic [7:0] tx_byte,
	output logic       nack,
	output logic       rx_valid,
	output logic [7:0] rx_byte,
	output logic [2:0] rx_index,
	output logic       done_res
);

	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	result_t    res_s2;
	seq_state_t state_q;
	seq_state_t state_next;
	result_t    res_next;
	logic       adv_s1;
	logic       load_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || adv_s1) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= '{command: command, read_mode: read_mode, addr_byte: addr_byte,
				reg_addr: reg_addr, write_byte: write_byte, last_index: last_index,
				start_seen: start_seen, rx_full: rx_full, rx_data: rx_data};
		end
	end

	i2cseq_step u_step (
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_next),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 || !out_stall) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = valid_s2;
	assign action    = res_s2.action;
	assign tx_byte   = res_s2.tx_byte;
	assign nack      = res_s2.nack;
	assign rx_valid  = res_s2.rx_valid;
	assign rx_byte   = res_s2.rx_byte;
	assign rx_index  = res_s2.rx_index;
	assign done_res  = res_s2.done_res;

endmodule
`default_nettype wire
